// ===== design/sgdlr_pkg.sv =====
// Shared types, command codes and helper functions for the SGD linear regression trainer.
// Used by the controller, the datapath and the top level; depends on nothing else.
package sgdlr_pkg;

  localparam logic [1:0] CMD_TRAIN   = 2'd0;
  localparam logic [1:0] CMD_PREDICT = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN            = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FEATURES_IN_USE = 2'd1;

  localparam logic [15:0] GAIN_RESET            = 16'd655;
  localparam logic [4:0]  FEATURES_IN_USE_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] feature;
    logic signed [15:0] target;
    logic               last;
    logic [4:0]         coef_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] prediction;
    logic signed [31:0] error;
    logic               status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic feat_step;
    logic read_coef;
    logic mul;
    logic acc;
    logic pred;
    logic err;
    logic step;
    logic bias;
    logic upd_read;
    logic upd_mul;
    logic upd_write;
    logic coef_result;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_none;
    logic is_read;
    logic is_predict;
    logic last;
    logic mismatch;
    logic upd_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x[63:31] == '0 || x[63:31] == '1) begin
      r = x[31:0];
    end else if (x[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== design/sgdlr_ctrl.sv =====
// Controller state machine of the SGD linear regression trainer.
// Depends on sgdlr_pkg for the command and status structs.
module sgdlr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  output sgdlr_pkg::dp_cmd_t dp_cmd,
  input  sgdlr_pkg::dp_sts_t dp_sts
);
  import sgdlr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_PRED   = 4'd4;
  localparam logic [3:0] S_ERR    = 4'd5;
  localparam logic [3:0] S_STEP   = 4'd6;
  localparam logic [3:0] S_BIAS   = 4'd7;
  localparam logic [3:0] S_URD    = 4'd8;
  localparam logic [3:0] S_UMUL   = 4'd9;
  localparam logic [3:0] S_UWR    = 4'd10;
  localparam logic [3:0] S_RDC    = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    item_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (dp_sts.is_none) begin
          state_next = S_IDLE;
        end else if (dp_sts.is_read) begin
          dp_cmd.read_coef = 1'b1;
          state_next       = S_RDC;
        end else begin
          dp_cmd.feat_step = 1'b1;
          state_next       = S_MUL;
        end
      end
      S_MUL: begin
        dp_cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        dp_cmd.acc = 1'b1;
        state_next = dp_sts.last ? S_PRED : S_IDLE;
      end
      S_PRED: begin
        dp_cmd.pred = 1'b1;
        // A count mismatch or a predict sample ends here without any update.
        if (dp_sts.mismatch || dp_sts.is_predict) begin
          state_next = S_OUT;
        end else begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        dp_cmd.err = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        dp_cmd.step = 1'b1;
        state_next  = S_BIAS;
      end
      S_BIAS: begin
        dp_cmd.bias = 1'b1;
        state_next  = S_URD;
      end
      S_URD: begin
        dp_cmd.upd_read = 1'b1;
        state_next      = S_UMUL;
      end
      S_UMUL: begin
        dp_cmd.upd_mul = 1'b1;
        state_next     = S_UWR;
      end
      S_UWR: begin
        dp_cmd.upd_write = 1'b1;
        state_next       = dp_sts.upd_last ? S_OUT : S_URD;
      end
      S_RDC: begin
        dp_cmd.coef_result = 1'b1;
        state_next         = S_OUT;
      end
      S_OUT: begin
        if (dp_sts.out_free) begin
          dp_cmd.load_out = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_out_to_idle: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load_out |=> state == S_IDLE)
    else $error("controller did not return to idle after loading a result");

  a_update_loop: assert property (@(posedge clk) disable iff (rst)
    state == S_UWR && !dp_sts.upd_last |=> state == S_URD)
    else $error("weight update pass ended early");

  a_mismatch_skips_update: assert property (@(posedge clk) disable iff (rst)
    state == S_PRED && dp_sts.mismatch |=> state == S_OUT)
    else $error("mismatched sample went on to an update");

endmodule

// ===== design/sgdlr_dp.sv =====
// Datapath of the SGD linear regression trainer: configuration registers, feature and
// weight memories, accumulator, shared multiplier and the result register. Uses sgdlr_pkg.
module sgdlr_dp #(
  parameter int MAX_FEATURES = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sgdlr_pkg::in_item_t                     item,
  input  sgdlr_pkg::dp_cmd_t                      dp_cmd,
  output sgdlr_pkg::dp_sts_t                      dp_sts,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output sgdlr_pkg::out_item_t                    result,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sgdlr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sgdlr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import sgdlr_pkg::*;

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW = $clog2(MAX_FEATURES + 2);

  logic [15:0]        gain;
  logic [4:0]         features_in_use;
  in_item_t           item_r;

  logic signed [31:0] wmem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] wvalid;
  logic signed [15:0] fmem [MAX_FEATURES];
  logic signed [31:0] w_rd;
  logic signed [15:0] f_rd;
  logic [AW-1:0]      w_addr;
  logic               w_rd_en;

  logic signed [31:0] bias;
  logic signed [47:0] acc;
  logic [CW-1:0]      count;
  logic               acc_en;
  logic signed [47:0] prod;
  logic signed [31:0] res_pred;
  logic signed [31:0] res_err;
  logic               res_status;
  logic signed [31:0] step;
  logic [AW-1:0]      k;

  logic [CW-1:0]      n_used;
  logic               count_room;
  logic               mismatch;
  logic               coef_lt;
  logic               coef_eq;
  logic signed [31:0] step_now;
  logic signed [39:0] upd_delta;
  logic signed [31:0] w_new;
  logic signed [31:0] pred_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= GAIN_RESET;
      features_in_use <= FEATURES_IN_USE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN:            gain            <= cfg_data;
        CFG_FEATURES_IN_USE: features_in_use <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one feature and anything beyond the buffer depth as the full depth.
  always_comb begin
    if (features_in_use == '0) begin
      n_used = CW'(1);
    end else if (int'(features_in_use) > MAX_FEATURES) begin
      n_used = CW'(MAX_FEATURES);
    end else begin
      n_used = CW'(features_in_use);
    end
  end

  assign count_room = int'(count) < MAX_FEATURES;
  assign mismatch   = count != n_used;
  assign coef_lt    = int'(item_r.coef_index) < int'(n_used);
  assign coef_eq    = int'(item_r.coef_index) == int'(n_used);
  assign step_now   = $signed(prod[47:16]);
  assign upd_delta  = $signed(prod[47:8]);
  assign w_new      = sat32(64'(w_rd) - 64'(upd_delta));
  assign pred_sum   = sat32(64'(acc) + 64'(bias));

  always_comb begin
    if (dp_cmd.upd_read) begin
      w_addr = k;
    end else if (dp_cmd.read_coef) begin
      w_addr = AW'(item_r.coef_index);
    end else begin
      w_addr = count[AW-1:0];
    end
  end

  assign w_rd_en = dp_cmd.upd_read | (dp_cmd.read_coef & coef_lt) |
                   (dp_cmd.feat_step & count_room);

  // Weight and feature memories with registered reads.
  always_ff @(posedge clk) begin
    if (w_rd_en) begin
      w_rd <= wvalid[w_addr] ? wmem[w_addr] : '0;
    end
    if (dp_cmd.upd_read) begin
      f_rd <= fmem[k];
    end
    if (dp_cmd.feat_step && count_room) begin
      fmem[count[AW-1:0]] <= item_r.feature;
    end
    if (dp_cmd.upd_write) begin
      wmem[k] <= w_new;
    end
  end

  // A weight never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (dp_cmd.upd_write) begin
      wvalid[k] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias  <= '0;
      acc   <= '0;
      count <= '0;
    end else begin
      if (dp_cmd.feat_step && int'(count) <= MAX_FEATURES) begin
        count <= count + CW'(1);
      end
      if (dp_cmd.acc && acc_en) begin
        acc <= acc + 48'($signed(prod[47:8]));
      end
      if (dp_cmd.pred) begin
        acc   <= '0;
        count <= '0;
      end
      if (dp_cmd.bias) begin
        bias <= sat32(64'(bias) - 64'(step_now));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      item_r <= item;
    end
    if (dp_cmd.feat_step) begin
      acc_en <= count_room;
    end
    if (dp_cmd.mul) begin
      prod <= 48'(item_r.feature) * 48'(w_rd);
    end
    if (dp_cmd.step) begin
      prod <= 48'($signed({1'b0, gain})) * 48'(res_err);
    end
    if (dp_cmd.upd_mul) begin
      prod <= 48'(step) * 48'(f_rd);
    end
    if (dp_cmd.pred) begin
      res_pred   <= mismatch ? '0 : pred_sum;
      res_err    <= '0;
      res_status <= mismatch;
    end
    if (dp_cmd.err) begin
      res_err <= sat32(64'(res_pred) - (64'(item_r.target) <<< 8));
    end
    if (dp_cmd.coef_result) begin
      res_pred   <= coef_lt ? w_rd : (coef_eq ? bias : '0);
      res_err    <= '0;
      res_status <= !(coef_lt || coef_eq);
    end
    if (dp_cmd.bias) begin
      step <= step_now;
      k    <= '0;
    end
    if (dp_cmd.upd_write) begin
      k <= k + AW'(1);
    end
    if (dp_cmd.load_out) begin
      result.prediction <= res_pred;
      result.error      <= res_err;
      result.status     <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (dp_cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    dp_sts.is_none    = item_r.cmd == CMD_NONE;
    dp_sts.is_read    = item_r.cmd == CMD_READ;
    dp_sts.is_predict = item_r.cmd == CMD_PREDICT;
    dp_sts.last       = item_r.last;
    dp_sts.mismatch   = mismatch;
    dp_sts.upd_last   = int'(k) == int'(n_used) - 1;
    dp_sts.out_free   = !result_valid || result_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_FEATURES + 1)
    else $error("element count ran past its saturation value");

  a_sample_clears: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.pred |=> count == '0 && acc == '0)
    else $error("sample state not cleared after the last feature");

  a_error_result_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> result.prediction == '0 && result.error == '0)
    else $error("failed result carries a non-zero value");

endmodule

// ===== design/sgd_linear_regression_trainer_core.sv =====
// Top level of the SGD linear regression trainer: joins the controller and the datapath.
// Depends on sgdlr_pkg, sgdlr_ctrl and sgdlr_dp.
//
// Usage. Items arrive on the item channel (valid/ready), one feature per transfer; cmd
// selects train, predict or coefficient read, and last marks the final feature of a
// sample. Results leave on the result channel (valid/ready): one per last feature and
// one per read, none for other features or for none commands. The configuration
// channel (always ready) writes the step size (index 0) and features_in_use (index 1);
// the user must do so only while the block is idle, which the block does not enforce.
// A feature that is not last frees the item channel after decode with its weight read,
// multiply and accumulate. A predict or mismatched sample then forms its prediction and
// loads its result; a read fetches its coefficient and loads it. A training sample runs
// the error, step and bias stages and then a weight update pass of read, multiply and
// write per feature over the single weight memory port before its result is loaded.
// Reset clears weights, bias, the accumulator and the count, and restores the register
// defaults; no clearing pass is needed. A finished result is held in an output register,
// so while the receiver stalls the block goes on taking features; only a further result
// waits until the held one has been transferred.
module sgd_linear_regression_trainer_core #(
  parameter int MAX_FEATURES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  sgdlr_pkg::in_item_t               item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output sgdlr_pkg::out_item_t              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgdlr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sgdlr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sgdlr_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  sgdlr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts)
  );

  sgdlr_dp #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .dp_cmd       (dp_cmd),
    .dp_sts       (dp_sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

// ===== sim/sgd_linear_regression_trainer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the SGD linear regression trainer core.
// Needs sgdlr_pkg and the core; predicts results with its own fixed-point LMS model or a fixed row value.
module sgd_linear_regression_trainer_core_tb;
  import sgdlr_pkg::*;

  localparam int     MAXF        = 16;
  localparam int     ITEM_TARGET = 1800;
  localparam int     PHASE_ITEMS = 150;
  localparam int     SETTLE      = 16;
  localparam int     QUIET_LIMIT = 1000;
  localparam longint CLIP_HI     = 64'sd2147483647;
  localparam longint CLIP_LO     = -64'sd2147483648;

  typedef struct {
    in_item_t  it;
    bit        fixed;
    out_item_t want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  in_item_t               item;
  logic                   result_valid;
  logic                   result_ready;
  out_item_t              result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Model state: buffered features, coefficients, running dot product, registers.
  logic signed [15:0] feat_buf [MAXF];
  logic signed [31:0] coef_w [MAXF];
  logic signed [31:0] coef_bias;
  longint             dot_acc;
  int unsigned        sample_len;
  logic [15:0]        rate;
  logic [4:0]         fiu_reg;

  out_item_t expected_results [$];
  stim_row_t directed_rows [$];

  int        errors;
  int        items_taken;
  int        results_seen;
  int        cfg_writes;
  int        items_sent;
  int        samples_sent;
  int        reads_sent;
  int        phases_done;
  int        quiet_cycles;
  bit        idle_on;
  bit        row_fixed;
  out_item_t row_want;

  sgd_linear_regression_trainer_core #(.MAX_FEATURES(MAXF)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > CLIP_HI) return CLIP_HI[31:0];
    if (x < CLIP_LO) return CLIP_LO[31:0];
    return x[31:0];
  endfunction

  function automatic int unsigned used_features();
    if (fiu_reg == 0) return 1;
    if (fiu_reg > MAXF) return MAXF;
    return 32'(fiu_reg);
  endfunction

  function automatic void reset_model();
    foreach (coef_w[k]) begin
      coef_w[k] = '0;
      feat_buf[k] = '0;
    end
    coef_bias = '0;
    dot_acc = 0;
    sample_len = 0;
    rate = GAIN_RESET;
    fiu_reg = FEATURES_IN_USE_RESET;
  endfunction

  // One LMS step: answer a read, accumulate a feature, or on the last one predict, and for a
  // training sample update bias and weights. Returns 1 when a result is due.
  function automatic bit lms_step(input in_item_t it, output out_item_t r);
    int unsigned        n;
    int unsigned        cnt;
    longint             acc;
    longint             step_w;
    longint             d;
    logic signed [31:0] pred;
    logic signed [31:0] err;
    logic signed [31:0] step;
    r = '0;
    n = used_features();
    if (it.cmd == CMD_NONE) return 0;
    if (it.cmd == CMD_READ) begin
      if (it.coef_index < n) r.prediction = coef_w[it.coef_index];
      else if (it.coef_index == n) r.prediction = coef_bias;
      else r.status = 1'b1;
      return 1;
    end
    if (sample_len < MAXF) begin
      feat_buf[sample_len] = $signed(it.feature);
      dot_acc += (longint'($signed(it.feature)) * longint'(coef_w[sample_len])) >>> 8;
    end
    if (sample_len <= MAXF) sample_len++;
    if (!it.last) return 0;
    cnt = sample_len;
    acc = dot_acc;
    sample_len = 0;
    dot_acc = 0;
    if (cnt != n) begin
      r.status = 1'b1;
      return 1;
    end
    pred = clip32(acc + longint'(coef_bias));
    r.prediction = pred;
    if (it.cmd == CMD_PREDICT) return 1;
    err = clip32(longint'(pred) - longint'($signed(it.target)) * 256);
    step_w = (longint'(rate) * longint'(err)) >>> 16;
    step = step_w[31:0];
    coef_bias = clip32(longint'(coef_bias) - longint'(step));
    for (int k = 0; k < n; k++) begin
      d = (longint'(step) * longint'(feat_buf[k])) >>> 8;
      coef_w[k] = clip32(longint'(coef_w[k]) - d);
    end
    r.error = err;
    return 1;
  endfunction

  function automatic in_item_t item_of(input logic [1:0] cmd, input logic [15:0] feat,
                                       input logic [15:0] targ, input logic last,
                                       input logic [4:0] idx);
    in_item_t it;
    it.cmd = cmd;
    it.feature = feat;
    it.target = targ;
    it.last = last;
    it.coef_index = idx;
    return it;
  endfunction

  function automatic out_item_t res(input logic [31:0] p, input logic [31:0] e,
                                    input logic s);
    out_item_t r;
    r.prediction = p;
    r.error = e;
    r.status = s;
    return r;
  endfunction

  function automatic void add_row(input in_item_t it, input bit fixed, input out_item_t want);
    stim_row_t row;
    row.it = it;
    row.fixed = fixed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Mostly full-range Q8.8 values, with a share of small ones so learning stays meaningful.
  function automatic logic [15:0] rand_q88();
    int v;
    if ($urandom_range(0, 9) < 6) return 16'($urandom);
    v = $urandom_range(0, 1024) - 512;
    return 16'(v);
  endfunction

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Results are checked before the item of the same edge is predicted, which keeps
  // the expectation queue in order even when both transfers coincide.
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (!rst) begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: result with none expected, expected nothing, actual %0d %0d %0d",
                     $time, result.prediction, result.error, result.status);
        end else begin
          want = expected_results.pop_front();
          compare_field("prediction", want.prediction, result.prediction);
          compare_field("error", want.error, result.error);
          compare_field("status", want.status, result.status);
        end
      end
      if (item_valid && item_ready) begin
        items_taken++;
        if (lms_step(item, got)) begin
          if (row_fixed) got = row_want;
          expected_results.push_back(got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index == CFG_GAIN) rate = cfg_data;
        else if (cfg_index == CFG_FEATURES_IN_USE) fiu_reg = cfg_data[4:0];
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog expired at %0t with %0d results outstanding", $time,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: a fresh stall before each result transfer while idling is on.
  initial begin
    int stall;
    int seen;
    result_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      seen = results_seen;
      do @(negedge clk); while (results_seen == seen);
    end
  end

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input in_item_t it);
    int gap;
    int seen;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    seen = items_taken;
    do @(negedge clk); while (items_taken == seen);
    if (it.cmd != CMD_NONE) items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    // A feature without a result may still be in flight.
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] lr, input logic [4:0] nf);
    int seen;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? CFG_GAIN : CFG_FEATURES_IN_USE;
      cfg_data <= (i == 0) ? lr : {11'($urandom), nf};
      cfg_valid <= 1'b1;
      seen = cfg_writes;
      do @(negedge clk); while (cfg_writes == seen);
    end
    cfg_valid <= 1'b0;
    phases_done++;
  endtask

  task automatic send_read(input int unsigned n);
    logic [4:0] idx;
    idx = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, n + 1));
    push_item(item_of(CMD_READ, 16'($urandom), 16'($urandom), 1'($urandom), idx));
    reads_sent++;
  endtask

  // A sample of len features; mix picks the command of each feature at random.
  task automatic send_sample(input int len, input bit train, input bit mix, input int n);
    logic [1:0] cmd;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_read(n);
      if (mix) cmd = $urandom_range(0, 1) ? CMD_TRAIN : CMD_PREDICT;
      else cmd = train ? CMD_TRAIN : CMD_PREDICT;
      push_item(item_of(cmd, rand_q88(), rand_q88(), i == len - 1, 5'($urandom)));
    end
    samples_sent++;
  endtask

  initial begin
    logic [15:0] lr;
    logic [4:0]  nf;
    int          phase;
    int          phase_end;
    int          pick;
    int unsigned n;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    row_fixed = 1'b0;
    row_want = '0;
    reset_model();

    // Directed rows, run with three features in use.
    add_row(item_of(CMD_READ, 16'h0000, 16'h0000, 1'b0, 5'd0), 1, res(0, 0, 0));
    add_row(item_of(CMD_READ, 16'h0000, 16'h0000, 1'b0, 5'd3), 1, res(0, 0, 0));
    add_row(item_of(CMD_READ, 16'hffff, 16'hffff, 1'b0, 5'd4), 1, res(0, 0, 1));
    add_row(item_of(CMD_READ, 16'h8000, 16'h7fff, 1'b1, 5'd31), 1, res(0, 0, 1));
    add_row(item_of(CMD_NONE, 16'h7fff, 16'h8000, 1'b1, 5'd0), 0, '0);
    add_row(item_of(CMD_TRAIN, 16'h7fff, 16'h0000, 1'b0, 5'd31), 0, '0);
    add_row(item_of(CMD_TRAIN, 16'h8000, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_TRAIN, 16'h0100, 16'h7fff, 1'b1, 5'd0), 1, res(0, -32'sd8388352, 0));
    add_row(item_of(CMD_PREDICT, 16'h0100, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_PREDICT, 16'hff00, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_PREDICT, 16'h0000, 16'h0000, 1'b1, 5'd0), 0, '0);
    add_row(item_of(CMD_PREDICT, 16'h0064, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_PREDICT, 16'h0064, 16'h0000, 1'b1, 5'd0), 1, res(0, 0, 1));
    add_row(item_of(CMD_TRAIN, 16'hffff, 16'h8000, 1'b1, 5'd0), 1, res(0, 0, 1));
    add_row(item_of(CMD_TRAIN, 16'h0080, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_READ, 16'h0000, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_TRAIN, 16'hff80, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_TRAIN, 16'h0200, 16'h8000, 1'b1, 5'd0), 0, '0);
    add_row(item_of(CMD_READ, 16'h0000, 16'h0000, 1'b0, 5'd3), 0, '0);
    add_row(item_of(CMD_READ, 16'h0000, 16'h0000, 1'b0, 5'd1), 0, '0);
    add_row(item_of(CMD_PREDICT, 16'h0000, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_PREDICT, 16'h7fff, 16'h0000, 1'b0, 5'd0), 0, '0);
    add_row(item_of(CMD_PREDICT, 16'h8000, 16'h0000, 1'b1, 5'd0), 0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    program_regs(GAIN_RESET, 5'd3);
    foreach (directed_rows[i]) begin
      row_fixed = directed_rows[i].fixed;
      row_want = directed_rows[i].want;
      push_item(directed_rows[i].it);
    end
    row_fixed = 1'b0;

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin lr = 16'd1000; nf = 5'd2; end
        1: begin lr = 16'd0; nf = 5'd1; end
        2: begin lr = 16'hffff; nf = 5'd16; end
        3: begin lr = 16'($urandom_range(1, 2000)); nf = 5'd0; end
        4: begin lr = 16'($urandom_range(1, 2000)); nf = 5'd17; end
        5: begin lr = 16'($urandom_range(1, 2000)); nf = 5'd31; end
        default: begin
          lr = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2000));
          nf = $urandom_range(0, 7) == 0 ? 5'd16 : 5'($urandom_range(1, 5));
        end
      endcase
      drain();
      program_regs(lr, nf);
      idle_on = $urandom_range(0, 3) != 0;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
        n = used_features();
        pick = $urandom_range(0, 99);
        if (pick < 65) send_sample(n, $urandom_range(0, 2) != 0, 1'b0, n);
        else if (pick < 80) send_read(n);
        else if (pick < 93) send_sample($urandom_range(1, 20), 1'($urandom), 1'($urandom), n);
        else push_item(item_of(CMD_NONE, 16'($urandom), 16'($urandom), 1'($urandom),
                               5'($urandom)));
      end
      phase++;
    end

    drain();
    repeat (60) @(negedge clk);
    $display("Covered %0d items over %0d register settings: %0d samples, %0d reads.",
             items_sent, phases_done, samples_sent, reads_sent);
    $display("Checked %0d results with %0d mismatches.", results_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sgd_linear_regression_trainer_core.f =====
design/sgdlr_pkg.sv
design/sgdlr_ctrl.sv
design/sgdlr_dp.sv
design/sgd_linear_regression_trainer_core.sv
sim/sgd_linear_regression_trainer_core_tb.sv
